FILE: hw/rtl/ilse_pkg.sv
// Shared types, codes and index helpers for the Ising lattice spin engine.
`timescale 1ns / 1ps

package ilse_pkg;

    localparam int IDX_W = 8;   // lattice index width, covers any row or column up to 256
    localparam int DIM_W = 7;
    localparam int J_W   = 11;
    localparam int DE_W  = 15;
    localparam int TE_W  = 25;
    localparam int MAG_W = 14;

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_FLIP   = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_SET_UP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_ROWS     = 2'd0,
        CFG_COLS     = 2'd1,
        CFG_COUPLING = 2'd2
    } cfg_idx_t;

    // effective dimensions (already clamped) and coupling
    typedef struct packed {
        logic [DIM_W-1:0]      rows;
        logic [DIM_W-1:0]      cols;
        logic signed [J_W-1:0] coupling;
    } cfg_t;

    // per-item update of the running totals
    typedef struct packed {
        logic              valid;
        logic              set_all;
        logic              flip;
        logic              spin_up;
        logic signed [3:0] nsum;
    } upd_t;

    // clamp an addressed row or column to the last one in use
    function automatic logic [IDX_W-1:0] sat_idx(input logic [5:0] v,
                                                 input logic [DIM_W-1:0] n);
        logic [IDX_W-1:0] v8;
        logic [IDX_W-1:0] n8;
        v8 = IDX_W'(v);
        n8 = IDX_W'(n);
        if (v8 >= n8)
            return n8 - IDX_W'(1);
        return v8;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] x,
                                                  input logic [DIM_W-1:0] n);
        logic [IDX_W-1:0] n8;
        n8 = IDX_W'(n);
        return (x == '0) ? n8 - IDX_W'(1) : x - IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
                                                  input logic [DIM_W-1:0] n);
        logic [IDX_W-1:0] n8;
        n8 = IDX_W'(n);
        return (x + IDX_W'(1) == n8) ? '0 : x + IDX_W'(1);
    endfunction

endpackage

FILE: hw/rtl/ilse_totals.sv
// Running bond sum and magnetization, and the registered totals of a result.
`timescale 1ns / 1ps

module ilse_totals
    import ilse_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  upd_t                    upd,
    input  logic                    capture,
    output logic signed [TE_W-1:0]  total_energy,
    output logic signed [MAG_W-1:0] total_magnetization
);

    localparam int RST_R = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int RST_C = (MAX_COLS < 64) ? MAX_COLS : 64;
    localparam int PW    = J_W + TE_W;
    localparam logic [TE_W-1:0]  BOND_RESET = TE_W'(2 * RST_R * RST_C);
    localparam logic [MAG_W-1:0] MAG_RESET  = MAG_W'(RST_R * RST_C);

    logic [TE_W-1:0]  bond_reg, bond_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [TE_W-1:0]  energy_reg;
    logic [MAG_W-1:0] mag_out_reg;

    logic [13:0]                   area;
    logic [TE_W-1:0]               dbond;
    logic signed [J_W+TE_W-1:0]    prod;
    logic signed [J_W+TE_W-1:0]    neg_prod;

    assign area  = 14'(cfg.rows) * 14'(cfg.cols);
    // 2 * nsum, sign extended
    assign dbond = {{(TE_W-5){upd.nsum[3]}}, upd.nsum, 1'b0};

    always_comb
    begin
        bond_next = bond_reg;
        mag_next  = mag_reg;
        if (upd.valid && upd.set_all)
        begin
            bond_next = TE_W'({area, 1'b0});
            mag_next  = area;
        end
        else if (upd.valid && upd.flip)
        begin
            bond_next = upd.spin_up ? bond_reg - dbond : bond_reg + dbond;
            mag_next  = upd.spin_up ? mag_reg - MAG_W'(2) : mag_reg + MAG_W'(2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bond_reg <= BOND_RESET;
            mag_reg  <= MAG_RESET;
        end
        else
        begin
            bond_reg <= bond_next;
            mag_reg  <= mag_next;
        end
    end

    assign prod     = PW'(cfg.coupling) * PW'($signed(bond_reg));
    assign neg_prod = -prod;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            energy_reg  <= neg_prod[TE_W-1:0];
            mag_out_reg <= mag_reg;
        end
    end

    assign total_energy        = $signed(energy_reg);
    assign total_magnetization = $signed(mag_out_reg);

endmodule

FILE: hw/rtl/ilse_engine.sv
// Site sequencer: spin memory, neighbour reads, energy change and write-back.
`timescale 1ns / 1ps

module ilse_engine
    import ilse_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   start,
    input  logic [1:0]             command,
    input  logic [5:0]             row,
    input  logic [5:0]             col,
    input  logic                   spin_value,
    output logic                   busy,
    output logic                   done,
    output logic signed [DE_W-1:0] energy_change,
    output logic                   site_spin,
    output upd_t                   upd,
    output logic                   capture
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RD1   = 6'b000010,
        ST_RD2   = 6'b000100,
        ST_CALC  = 6'b001000,
        ST_CLEAR = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    function automatic logic [AW-1:0] site_addr(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
        return {r[RW-1:0], c[CW-1:0]};
    endfunction

    logic spin_mem [DEPTH];

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             pend_reg, pend_next;
    logic             done_reg;

    cmd_t             cmd_reg;
    logic             wv_reg;
    logic [IDX_W-1:0] r_reg, c_reg;
    logic             s_reg, up_reg, dn_reg, lf_reg;
    logic             q_a_reg, q_b_reg;
    logic [DE_W-1:0]  de_reg;
    logic             spin_out_reg;

    logic             accept;
    logic [IDX_W-1:0] r_in, c_in, up_in, dn, lf, rt;
    logic [AW-1:0]    rd_addr_a, rd_addr_b, wr_addr;
    logic             wr_en, wr_data;
    logic [2:0]       ups;
    logic signed [3:0]  nsum;
    logic signed [15:0] jprod, de_pos, de_val;
    logic             flip;

    assign busy   = !(state_reg == ST_IDLE || state_reg == ST_OUT);
    assign accept = start && !busy;

    assign r_in  = sat_idx(row, cfg.rows);
    assign c_in  = sat_idx(col, cfg.cols);
    assign up_in = wrap_dec(r_in, cfg.rows);
    assign dn    = wrap_inc(r_reg, cfg.rows);
    assign lf    = wrap_dec(c_reg, cfg.cols);
    assign rt    = wrap_inc(c_reg, cfg.cols);

    // centre and upper neighbour are read on the accepting edge itself
    always_comb
    begin
        unique case (state_reg)
            ST_RD1:
            begin
                rd_addr_a = site_addr(dn, c_reg);
                rd_addr_b = site_addr(r_reg, lf);
            end
            ST_RD2:
            begin
                rd_addr_a = site_addr(r_reg, rt);
                rd_addr_b = site_addr(r_reg, rt);
            end
            default:
            begin
                rd_addr_a = site_addr(r_in, c_in);
                rd_addr_b = site_addr(up_in, c_in);
            end
        endcase
    end

    // right neighbour arrives straight from the read port in the combine cycle
    assign ups   = 3'(up_reg) + 3'(dn_reg) + 3'(lf_reg) + 3'(q_a_reg);
    assign nsum  = 4'($signed({1'b0, ups, 1'b0}) - 5'sd4);
    assign jprod = 16'(cfg.coupling) * 16'(nsum);
    assign de_pos = {jprod[14:0], 1'b0};
    assign de_val = s_reg ? de_pos : -de_pos;

    always_comb
    begin
        unique case (cmd_reg)
            CMD_QUERY:  flip = 1'b0;
            CMD_FLIP:   flip = 1'b1;
            CMD_WRITE:  flip = (wv_reg != s_reg);
            CMD_SET_UP: flip = 1'b0;
        endcase
    end

    // a query, flip or write writes once at most, before the next item's reads
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = site_addr(r_reg, c_reg);
        wr_data = !s_reg;
        if (state_reg == ST_CALC)
            wr_en = flip;
        else if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            spin_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        q_a_reg <= spin_mem[rd_addr_a];
        q_b_reg <= spin_mem[rd_addr_b];
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pend_next    = pend_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_RD1;
            ST_RD1:
                state_next = ST_RD2;
            ST_RD2:
                state_next = ST_CALC;
            ST_CALC:
                if (cmd_reg == CMD_SET_UP)
                begin
                    state_next   = ST_CLEAR;
                    clr_cnt_next = '0;
                    pend_next    = 1'b1;
                end
                else
                    state_next = ST_OUT;
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (&clr_cnt_reg)
                begin
                    state_next = pend_reg ? ST_OUT : ST_IDLE;
                    pend_next  = 1'b0;
                end
            end
            ST_OUT:
                state_next = start ? ST_RD1 : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
            done_reg    <= (state_reg == ST_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(command);
            wv_reg  <= spin_value;
            r_reg   <= r_in;
            c_reg   <= c_in;
        end
        if (state_reg == ST_RD1)
        begin
            s_reg  <= q_a_reg;
            up_reg <= q_b_reg;
        end
        if (state_reg == ST_RD2)
        begin
            dn_reg <= q_a_reg;
            lf_reg <= q_b_reg;
        end
        if (state_reg == ST_CALC)
        begin
            de_reg       <= de_val[DE_W-1:0];
            spin_out_reg <= (cmd_reg == CMD_SET_UP) ? 1'b1 : (s_reg ^ flip);
        end
    end

    assign upd.valid   = (state_reg == ST_CALC);
    assign upd.set_all = (cmd_reg == CMD_SET_UP);
    assign upd.flip    = flip;
    assign upd.spin_up = s_reg;
    assign upd.nsum    = nsum;

    assign capture       = (state_reg == ST_OUT);
    assign done          = done_reg;
    assign energy_change = $signed(de_reg);
    assign site_spin     = spin_out_reg;

endmodule

FILE: hw/rtl/ising_lattice_spin_engine_top.sv
// Top level of the Ising lattice spin engine: configuration registers and block wiring.
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// command   start / busy              command, row, col, spin_value
// result    done (one-cycle strobe)   energy_change, site_spin, total_energy,
//                                     total_magnetization
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// For query, flip and write, the two read ports of the spin memory fetch
// centre and four neighbours in three read slots, then ST_CALC combines and
// writes back; the next item can be taken in ST_OUT, and the result strobe
// is registered from ST_OUT and comes in the cycle after it.
// Set all up adds a sweep over all 2**clog2(MAX_ROWS) * 2**clog2(MAX_COLS)
// entries of the spin memory, one entry a cycle.
// After reset the same sweep runs with busy high.
// Results cannot be held off; config is always ready.

module ising_lattice_spin_engine_top
    import ilse_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              command,
    input  logic [5:0]              row,
    input  logic [5:0]              col,
    input  logic                    spin_value,
    output logic                    done,
    output logic signed [DE_W-1:0]  energy_change,
    output logic                    site_spin,
    output logic signed [TE_W-1:0]  total_energy,
    output logic signed [MAG_W-1:0] total_magnetization,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [J_W-1:0]          cfg_data
);

    logic [DIM_W-1:0]      rows_reg, cols_reg;
    logic signed [J_W-1:0] coupling_reg;
    logic [DIM_W-1:0]      rows_eff, cols_eff;
    cfg_t                  cfg;
    upd_t                  upd;
    logic                  capture;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= 7'd64;
            cols_reg     <= 7'd64;
            coupling_reg <= 11'sd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROWS:     rows_reg     <= cfg_data[DIM_W-1:0];
                CFG_COLS:     cols_reg     <= cfg_data[DIM_W-1:0];
                CFG_COUPLING: coupling_reg <= $signed(cfg_data);
                default:      ;
            endcase
        end
    end

    // clamp dimensions to 2 .. MAX
    always_comb
    begin
        if (rows_reg < 7'd2)
            rows_eff = 7'd2;
        else if (int'(rows_reg) > MAX_ROWS)
            rows_eff = 7'(MAX_ROWS);
        else
            rows_eff = rows_reg;
        if (cols_reg < 7'd2)
            cols_eff = 7'd2;
        else if (int'(cols_reg) > MAX_COLS)
            cols_eff = 7'(MAX_COLS);
        else
            cols_eff = cols_reg;
    end

    assign cfg.rows     = rows_eff;
    assign cfg.cols     = cols_eff;
    assign cfg.coupling = coupling_reg;

    ilse_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .start         (start),
        .command       (command),
        .row           (row),
        .col           (col),
        .spin_value    (spin_value),
        .busy          (busy),
        .done          (done),
        .energy_change (energy_change),
        .site_spin     (site_spin),
        .upd           (upd),
        .capture       (capture)
    );

    ilse_totals #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_totals (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg),
        .upd                 (upd),
        .capture             (capture),
        .total_energy        (total_energy),
        .total_magnetization (total_magnetization)
    );

`ifndef NO_ASSERTIONS
    // a taken item always occupies the engine on the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("engine not busy after taking an item");

    // a result follows a combine or sweep cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy, 2))
        else $error("result without preceding work");

    // results are never on consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result strobes");
`endif

endmodule
